FILE: hw/rtl/wia_pkg.sv
// ----------------------------------------------------------------------------
// wia_pkg
// Shared types and constants for the watermark id allocator.
// ----------------------------------------------------------------------------
package wia_pkg;

  localparam int ID_SPACE = 1024;
  localparam int ID_W     = $clog2(ID_SPACE);
  localparam int MARK_W   = ID_W + 1;

  localparam logic [2:0] OP_IS_FREE  = 3'd0;
  localparam logic [2:0] OP_FREE     = 3'd1;
  localparam logic [2:0] OP_GET      = 3'd2;
  localparam logic [2:0] OP_RESERVE  = 3'd3;
  localparam logic [2:0] OP_HAS_FREE = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [ID_W-1:0] id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] given_id;
    logic            answer;
    logic [1:0]      status;
  } rsp_t;

endpackage

FILE: hw/rtl/wia_ram.sv
// ----------------------------------------------------------------------------
// wia_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wia_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/wia_obuf.sv
// ----------------------------------------------------------------------------
// wia_obuf
// Response register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module wia_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  wia_pkg::rsp_t load_data,
  output logic          ready,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output wia_pkg::rsp_t rsp
);
  import wia_pkg::*;

  assign ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ready) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      rsp <= load_data;
    end
  end

endmodule

FILE: hw/rtl/wia_ctrl.sv
// ----------------------------------------------------------------------------
// wia_ctrl
// Sequencer: holds the marks and freed count, and reads, modifies and writes
// the freed bitmap in the RAM.
// ----------------------------------------------------------------------------
module wia_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  wia_pkg::req_t             req,
  output logic                      res_load,
  output wia_pkg::rsp_t             res,
  input  logic                      res_ready,
  output logic                      mem_we,
  output logic [wia_pkg::ID_W-1:0]  mem_waddr,
  output logic                      mem_wdata,
  output logic [wia_pkg::ID_W-1:0]  mem_raddr,
  input  logic                      mem_rdata
);
  import wia_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_LOOK = 6'b000100,
    S_ADV  = 6'b001000,
    S_FILL = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [MARK_W-1:0] low_mark, low_mark_next;
  logic [MARK_W-1:0] high_mark, high_mark_next;
  logic [MARK_W-1:0] freed_count, freed_count_next;
  logic [2:0]        cur_op;
  logic [ID_W-1:0]   cur_id;
  rsp_t              result, result_next;

  logic [MARK_W-1:0] id_ext;
  logic [MARK_W-1:0] low_inc;
  logic              in_band;
  logic              accept;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign id_ext    = {1'b0, cur_id};
  assign low_inc   = low_mark + MARK_W'(1);
  assign in_band   = (id_ext >= low_mark) && (id_ext < high_mark);
  assign res_load  = (state == S_RESP);
  assign res       = result;

  always_comb begin
    state_next       = state;
    low_mark_next    = low_mark;
    high_mark_next   = high_mark;
    freed_count_next = freed_count;
    result_next      = result;
    mem_we           = 1'b0;
    mem_waddr        = cur_id;
    mem_wdata        = 1'b0;
    mem_raddr        = cur_id;

    case (state)
      S_IDLE: begin
        if (accept) begin
          result_next = '0;
          state_next  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_RESP;
        case (cur_op)
          OP_IS_FREE: begin
            if (in_band) begin
              state_next = S_LOOK;
            end else begin
              result_next.answer = 1'b1;
            end
          end
          OP_FREE: begin
            if (in_band) begin
              state_next = S_LOOK;
            end else begin
              result_next.status = ST_IGNORED;
            end
          end
          OP_GET: begin
            if (high_mark >= MARK_W'(ID_SPACE)) begin
              result_next.status = ST_ERROR;
            end else begin
              // entry joins the band in use: clear any stale bit
              result_next.given_id = high_mark[ID_W-1:0];
              mem_we               = 1'b1;
              mem_waddr            = high_mark[ID_W-1:0];
              high_mark_next       = high_mark + MARK_W'(1);
            end
          end
          OP_RESERVE: begin
            if (id_ext <= low_mark || id_ext >= MARK_W'(ID_SPACE)) begin
              result_next.status = ST_ERROR;
            end else if (id_ext >= high_mark) begin
              if (low_mark == high_mark) begin
                low_mark_next  = id_ext;
                high_mark_next = id_ext + MARK_W'(1);
                mem_we         = 1'b1;
              end else begin
                state_next = S_FILL;
              end
            end else begin
              state_next = S_LOOK;
            end
          end
          OP_HAS_FREE: begin
            result_next.answer = (freed_count != '0);
          end
          default: begin
            result_next.status = ST_ERROR;
          end
        endcase
      end

      // bitmap bit of cur_id is on the read port
      S_LOOK: begin
        state_next = S_RESP;
        case (cur_op)
          OP_IS_FREE: begin
            result_next.answer = mem_rdata;
          end
          OP_FREE: begin
            if (mem_rdata) begin
              result_next.status = ST_IGNORED;
            end else if (id_ext == low_mark) begin
              low_mark_next = low_inc;
              if (low_inc < high_mark) begin
                mem_raddr  = low_inc[ID_W-1:0];
                state_next = S_ADV;
              end
            end else begin
              mem_we           = 1'b1;
              mem_wdata        = 1'b1;
              freed_count_next = freed_count + MARK_W'(1);
            end
          end
          OP_RESERVE: begin
            if (!mem_rdata) begin
              result_next.status = ST_ERROR;
            end else begin
              mem_we           = 1'b1;
              freed_count_next = freed_count - MARK_W'(1);
            end
          end
          default: begin
            result_next.status = ST_ERROR;
          end
        endcase
      end

      // low mark walks over freed ids; read of the next entry overlaps the
      // clearing write of this one
      S_ADV: begin
        if (mem_rdata) begin
          mem_we           = 1'b1;
          mem_waddr        = low_mark[ID_W-1:0];
          freed_count_next = freed_count - MARK_W'(1);
          low_mark_next    = low_inc;
          if (low_inc < high_mark) begin
            mem_raddr = low_inc[ID_W-1:0];
          end else begin
            state_next = S_RESP;
          end
        end else begin
          state_next = S_RESP;
        end
      end

      // skipped ids are marked freed, then the reserved id enters as in use
      S_FILL: begin
        mem_we = 1'b1;
        if (high_mark < id_ext) begin
          mem_waddr        = high_mark[ID_W-1:0];
          mem_wdata        = 1'b1;
          freed_count_next = freed_count + MARK_W'(1);
          high_mark_next   = high_mark + MARK_W'(1);
        end else begin
          high_mark_next = id_ext + MARK_W'(1);
          state_next     = S_RESP;
        end
      end

      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      low_mark    <= '0;
      high_mark   <= '0;
      freed_count <= '0;
    end else begin
      state       <= state_next;
      low_mark    <= low_mark_next;
      high_mark   <= high_mark_next;
      freed_count <= freed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (accept) begin
      cur_op <= req.opcode;
      cur_id <= req.id;
    end
  end

`ifndef SYNTHESIS
  a_marks_ordered: assert property (@(posedge clk) disable iff (rst)
    low_mark <= high_mark)
    else $error("low mark above high mark");

  a_high_bounded: assert property (@(posedge clk) disable iff (rst)
    high_mark <= MARK_W'(ID_SPACE))
    else $error("high mark beyond id space");

  a_count_in_band: assert property (@(posedge clk) disable iff (rst)
    freed_count <= high_mark - low_mark)
    else $error("freed count exceeds band between marks");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted beat did not start execution");

  a_adv_in_band: assert property (@(posedge clk) disable iff (rst)
    state == S_ADV |-> low_mark < high_mark)
    else $error("low mark walk left the band");
`endif

endmodule

FILE: hw/rtl/watermark_id_allocator.sv
// ----------------------------------------------------------------------------
// watermark_id_allocator
// Id allocator with low and high marks and a bitmap of freed ids between them.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and gives one response beat. Get,
// has_free, bad opcodes and requests settled by the marks alone go from the
// execute state straight to the response state; is_free, free and reserve
// that need the bitmap pass through a bitmap look-up state in between.
// Freeing the low mark then walks the low mark over each freed id that
// follows it, until it reaches an id still in use or the high mark, and
// reserving beyond the high mark walks over each id skipped. The bitmap
// lives in a 1-bit RAM with one write and one registered read port, and
// these walks are bound by that port pair. No clearing pass follows reset:
// an entry is written as it enters the band between the marks, so requests
// are taken from the first cycle after reset.
module watermark_id_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  wia_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output wia_pkg::rsp_t rsp
);
  import wia_pkg::*;

  logic            res_load;
  logic            res_ready;
  rsp_t            res;
  logic            mem_we;
  logic [ID_W-1:0] mem_waddr;
  logic            mem_wdata;
  logic [ID_W-1:0] mem_raddr;
  logic            mem_rdata;

  wia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_load  (res_load),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  wia_ram #(
    .WIDTH (1),
    .DEPTH (ID_SPACE)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wia_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_data (res),
    .ready     (res_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: tb/tb_watermark_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_watermark_id_allocator
// Self-checking bench: a mirror of the low mark, high mark and freed-id set
// predicts each response beat, which is checked against the block's output.
// ----------------------------------------------------------------------------
module tb_watermark_id_allocator;
  import wia_pkg::*;

  localparam logic [2:0]  OP_FIRST_UNUSED = OP_HAS_FREE + 3'd1;
  localparam int          HIGH_CEILING    = 900;  // keep random traffic off exhaustion
  localparam int          DRAIN_CYCLES    = 20000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // mirror of the allocator state
  logic [MARK_W-1:0] mark_lo     = '0;
  logic [MARK_W-1:0] mark_hi     = '0;
  logic [MARK_W-1:0] freed_total = '0;
  bit                freed_set [ID_SPACE];

  rsp_t awaited_rsp[$];
  int   fault_count = 0;
  bit   idle_on     = 1'b1;
  int   stall_left  = 0;

  watermark_id_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd100_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit is_free_now(logic [ID_W-1:0] id);
    return ({1'b0, id} < mark_lo) || ({1'b0, id} >= mark_hi) || freed_set[id];
  endfunction

  // Advances the mirror by one request and returns the response it must give.
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    o = '0;
    o.status = ST_DONE;
    case (r.opcode)
      OP_IS_FREE: o.answer = is_free_now(r.id);
      OP_FREE: begin
        if (is_free_now(r.id)) begin
          o.status = ST_IGNORED;
        end else if ({1'b0, r.id} == mark_lo) begin
          mark_lo++;
          while (mark_lo < mark_hi && freed_set[mark_lo[ID_W-1:0]]) begin
            freed_set[mark_lo[ID_W-1:0]] = 1'b0;
            freed_total--;
            mark_lo++;
          end
        end else begin
          freed_set[r.id] = 1'b1;
          freed_total++;
        end
      end
      OP_GET: begin
        if (mark_hi >= ID_SPACE) begin
          o.status = ST_ERROR;
        end else begin
          o.given_id = mark_hi[ID_W-1:0];
          mark_hi++;
        end
      end
      OP_RESERVE: begin
        if ({1'b0, r.id} <= mark_lo) begin
          o.status = ST_ERROR;
        end else if ({1'b0, r.id} >= mark_hi) begin
          if (mark_lo == mark_hi) begin
            mark_lo = {1'b0, r.id};
          end else begin
            // ids skipped over join the freed set
            while (mark_hi < {1'b0, r.id}) begin
              freed_set[mark_hi[ID_W-1:0]] = 1'b1;
              freed_total++;
              mark_hi++;
            end
          end
          mark_hi = {1'b0, r.id} + MARK_W'(1);
        end else if (!freed_set[r.id]) begin
          o.status = ST_ERROR;
        end else begin
          freed_set[r.id] = 1'b0;
          freed_total--;
        end
      end
      OP_HAS_FREE: o.answer = (freed_total != '0);
      default: o.status = ST_ERROR;
    endcase
    return o;
  endfunction

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Drives one request beat and records its expected response on acceptance.
  task automatic send_req(logic [2:0] op, logic [ID_W-1:0] id);
    int  gap;
    bit  taken;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      req_valid = 1'b0;
      req = req_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    req_valid  = 1'b1;
    req.opcode = op;
    req.id     = id;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !req_stall;
    end
    awaited_rsp.push_back(apply_request(req));
  endtask

  function automatic logic [ID_W-1:0] band_id();
    if (mark_hi > mark_lo) return ID_W'($urandom_range(mark_lo, mark_hi - 1));
    return ID_W'($urandom);
  endfunction

  // Mostly requests that land in or next to the band between the marks.
  task automatic pick_random_req(output logic [2:0] op, output logic [ID_W-1:0] id);
    int sel;
    int pick;
    sel  = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    id   = ID_W'($urandom);
    if (sel < 20) begin
      op = (mark_hi < HIGH_CEILING) ? OP_GET : OP_FREE;
      if (op == OP_FREE) id = mark_lo[ID_W-1:0];
    end else if (sel < 45) begin
      op = OP_FREE;
      if (pick < 3) id = mark_lo[ID_W-1:0];
      else if (pick < 8) id = band_id();
    end else if (sel < 60) begin
      op = OP_RESERVE;
      if (pick < 5) id = band_id();
      else if (pick < 8) id = ID_W'(mark_hi + $urandom_range(0, 7));
      else if (pick == 8) id = ID_W'(mark_hi + $urandom_range(8, 63));
      if ({1'b0, id} >= mark_hi && {1'b0, id} >= HIGH_CEILING) id = mark_lo[ID_W-1:0];
    end else if (sel < 78) begin
      op = OP_IS_FREE;
      if (pick < 5) id = band_id();
    end else if (sel < 88) begin
      op = OP_HAS_FREE;
    end else if (sel < 93) begin
      op = OP_FIRST_UNUSED + 3'($urandom_range(0, 2));
    end else begin
      op = OP_FREE;
      id = mark_lo[ID_W-1:0];
    end
  endtask

  // response-side stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        stall_left = 0;
        rsp_stall  = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall = 1'b1;
      end else if ($urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        rsp_stall  = 1'b1;
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsp.size() == 0) begin
        note_fault($sformatf("unexpected beat: given_id=%0d answer=%0b status=%0d",
                             rsp.given_id, rsp.answer, rsp.status));
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.given_id !== want.given_id || rsp.answer !== want.answer ||
            rsp.status !== want.status) begin
          note_fault($sformatf({"bad beat: expected given_id=%0d answer=%0b status=%0d,",
                                " got given_id=%0d answer=%0b status=%0d"},
                               want.given_id, want.answer, want.status,
                               rsp.given_id, rsp.answer, rsp.status));
        end
      end
    end
  end

  task automatic test_directed_cases;
    send_req(OP_HAS_FREE, '0);
    send_req(OP_IS_FREE, '0);
    send_req(OP_FREE, '0);          // already free: ignored
    send_req(OP_RESERVE, '0);       // not above low mark
    send_req(OP_RESERVE, 10'd5);    // marks equal: low mark jumps
    send_req(OP_IS_FREE, 10'd3);
    send_req(OP_IS_FREE, 10'd5);
    send_req(OP_GET, '1);
    send_req(OP_GET, '0);
    send_req(OP_GET, 10'h155);
    send_req(OP_RESERVE, 10'd12);   // skips 9..11 into the freed set
    send_req(OP_HAS_FREE, '1);
    send_req(OP_RESERVE, 10'd10);   // taken back from the freed set
    send_req(OP_RESERVE, 10'd10);   // in use, not freed
    send_req(OP_FREE, 10'd7);
    send_req(OP_FREE, 10'd7);
    send_req(OP_FREE, 10'd5);
    send_req(OP_FREE, 10'd6);       // low mark sweeps over 7
    send_req(OP_FREE, '1);
    send_req(OP_IS_FREE, '1);
    send_req(OP_FIRST_UNUSED, '1);
    send_req(OP_FIRST_UNUSED + 3'd1, 10'h2AA);
    send_req(OP_FIRST_UNUSED + 3'd2, 10'h155);
    send_req(OP_FREE, 10'd8);       // sweeps over 9, stops at 10
  endtask

  task automatic test_random_traffic;
    logic [2:0]      op;
    logic [ID_W-1:0] id;
    for (int blk = 0; blk < 10; blk++) begin
      idle_on = (blk % 4 != 3);
      repeat (50) begin
        pick_random_req(op, id);
        send_req(op, id);
      end
    end
  endtask

  task automatic test_steady_stream;
    logic [2:0]      op;
    logic [ID_W-1:0] id;
    idle_on = 1'b0;
    repeat (40) begin
      pick_random_req(op, id);
      send_req(op, id);
    end
  endtask

  // Longest walks both ways, then exhaustion and the drained end state.
  task automatic test_long_walks;
    idle_on = 1'b0;
    if (mark_hi < ID_SPACE - 1) send_req(OP_GET, ID_W'($urandom));
    send_req(OP_RESERVE, ID_W'(ID_SPACE - 1));
    send_req(OP_GET, '0);
    send_req(OP_HAS_FREE, '0);
    for (int n = ID_SPACE - 1; n > mark_lo; n--) begin
      if (!is_free_now(ID_W'(n))) send_req(OP_FREE, ID_W'(n));
    end
    send_req(OP_FREE, mark_lo[ID_W-1:0]);
    send_req(OP_IS_FREE, ID_W'(ID_SPACE - 1));
    send_req(OP_HAS_FREE, '0);
    send_req(OP_GET, '0);
    send_req(OP_RESERVE, ID_W'(ID_SPACE - 1));
    send_req(OP_FREE, ID_W'(ID_SPACE - 1));
  endtask

  initial begin
    int guard;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_random_traffic();
    test_steady_stream();
    test_long_walks();

    @(negedge clk);
    req_valid = 1'b0;
    guard = 0;
    while (awaited_rsp.size() != 0 && guard < DRAIN_CYCLES) begin
      @(posedge clk);
      guard++;
    end
    while (awaited_rsp.size() != 0) begin
      void'(awaited_rsp.pop_front());
      note_fault("response beat never arrived");
    end
    repeat (50) @(posedge clk);

    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
